// ----- design/tpp_pkg.sv -----
// Shared types, codes and helpers for the TFTP packet parser.
`timescale 1ns / 1ps
package tpp_pkg;

  // Compile-time ceiling on the payload limit
  localparam int unsigned MaxPayload = 512;
  localparam logic [10:0] LimCap     = 11'(MaxPayload);
  localparam logic [9:0]  CntMax     = 10'd1023;

  localparam logic [15:0] OpRrq   = 16'd1;
  localparam logic [15:0] OpWrq   = 16'd2;
  localparam logic [15:0] OpData  = 16'd3;
  localparam logic [15:0] OpAck   = 16'd4;
  localparam logic [15:0] OpError = 16'd5;

  localparam logic [0:0] CfgMaxPayload = 1'd0;
  localparam logic [0:0] CfgOpcodeMask = 1'd1;

  typedef enum logic [2:0] {
    PH_OPC,
    PH_NUM,
    PH_NAME,
    PH_MODE,
    PH_PAY,
    PH_EXCESS
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_OPCODE,
    ROLE_NUMBER,
    ROLE_NAME,
    ROLE_MODE,
    ROLE_PAYLOAD,
    ROLE_TERM,
    ROLE_EXCESS
  } role_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_BAD_REQ,
    ST_ILLEGAL_OP,
    ST_WRONG_MODE
  } status_e;

  typedef struct packed {
    logic [9:0]  byte_count;
    logic [15:0] opcode;
    logic [15:0] number;
    phase_e      phase;
    logic [9:0]  field_len;
    logic [2:0]  match_idx;
    logic        mismatch;
    logic        bad;
    logic [9:0]  name_len;
  } parse_state_t;

  typedef struct packed {
    logic [9:0] max_payload;
    logic [4:0] opcode_mask;
  } parse_cfg_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    role_e       role;
    logic        done;
    status_e     status;
    logic [15:0] opcode;
    logic [15:0] number;
    logic [9:0]  name_len;
    logic [9:0]  payload_len;
  } parse_res_t;

  localparam parse_state_t StateReset = '{
    byte_count: 10'd0, opcode: 16'd0, number: 16'd0, phase: PH_OPC,
    field_len: 10'd0, match_idx: 3'd0, mismatch: 1'b0, bad: 1'b0,
    name_len: 10'd0
  };

  // Expected lower-case mode string, one character per match position
  function automatic logic [7:0] octet_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6F; // o
      3'd1:    c = 8'h63; // c
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h65; // e
      3'd4:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- design/tftp_packet_parser_core.sv -----
// Top level of the TFTP packet parser: stream ports, state and result registers.
`timescale 1ns / 1ps
// Usage
//   Slave stream: one datagram byte per beat in s_axis_tdata_i, s_axis_tlast_i high on the
//   final byte. Master stream: one result beat per input beat carrying the byte, its role
//   (tuser) and, on the beat with m_axis_tlast_o high, the verdict fields in tdata.
//   Configuration: cfg_we_i with cfg_idx_i 0 writes max_payload, 1 writes the legal opcode
//   mask; write only while the parser has no beat in flight.
//   Output: each result is registered and appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while the output is not stalled; the parse state and the
//   result register each take a new value on every accepted byte.
//   Reset: parser returns to the opcode field, the result register empties, max_payload
//   goes to 512 and the opcode mask to 6 (WRQ and DATA legal).
//   Stall: while the result register is full and m_axis_tready_i is low, s_axis_tready_o
//   drops and the held result stays unchanged; no bytes are lost.
//   Each datagram's last byte returns the parser to its reset state for the next one.
module tftp_packet_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [7:0] byte_out, [10:8] status, [26:11] opcode,
                                        // [42:27] number, [52:43] name_len,
                                        // [62:53] payload_len, [63] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] role
  output logic        m_axis_tlast_o    // done_res
);
  import tpp_pkg::*;

  parse_cfg_t   cfg_q;
  parse_state_t state_q, state_d;
  parse_res_t   res_d, res_q;
  logic         out_valid_q;
  logic         in_fire;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  tpp_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .rx_byte_i (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .state_o   (state_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload <= 10'd512;
      cfg_q.opcode_mask <= 5'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxPayload: cfg_q.max_payload <= cfg_data_i;
        CfgOpcodeMask: cfg_q.opcode_mask <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: load on every accepted beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.done;
  assign m_axis_tuser_o  = res_q.role;
  assign m_axis_tdata_o  = {1'b0, res_q.payload_len, res_q.name_len, res_q.number,
                            res_q.opcode, res_q.status, res_q.byte_out};

endmodule

// ----- design/tpp_step.sv -----
// Per-beat parse step: next parser state and tagged result for one byte.
`timescale 1ns / 1ps
module tpp_step (
  input  tpp_pkg::parse_state_t state_i,
  input  tpp_pkg::parse_cfg_t   cfg_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  last_i,
  output tpp_pkg::parse_state_t state_o,
  output tpp_pkg::parse_res_t   res_o
);
  import tpp_pkg::*;

  parse_state_t s;
  parse_res_t   r;
  logic [15:0]  op;
  logic [10:0]  lim;
  logic [7:0]   lc;
  logic         op_num;
  logic         op_req;
  logic         op_legal;
  logic         ended_ok;
  logic [2:0]   mask_idx;

  always_comb begin
    s   = state_i;
    r   = '0;
    op  = state_i.opcode;
    lim = ({1'b0, cfg_i.max_payload} < LimCap) ? {1'b0, cfg_i.max_payload} : LimCap;
    lc  = ((rx_byte_i >= 8'h41) && (rx_byte_i <= 8'h5A)) ? rx_byte_i + 8'd32 : rx_byte_i;
    r.role = ROLE_EXCESS;

    if (state_i.byte_count < CntMax) begin
      s.byte_count = state_i.byte_count + 10'd1;
    end

    case (state_i.phase)
      PH_OPC: begin
        r.role = ROLE_OPCODE;
        if (state_i.byte_count == 10'd0) begin
          s.opcode = {rx_byte_i, 8'h00};
        end else begin
          s.opcode = {state_i.opcode[15:8], rx_byte_i};
          op       = s.opcode;
          if (op == OpRrq || op == OpWrq) begin
            s.phase = PH_NAME;
          end else if (op >= OpData && op <= OpError) begin
            s.phase = PH_NUM;
          end else begin
            s.bad   = 1'b1;
            s.phase = PH_EXCESS;
          end
        end
      end
      PH_NUM: begin
        r.role = ROLE_NUMBER;
        if (state_i.byte_count == 10'd2) begin
          s.number = {rx_byte_i, 8'h00};
        end else begin
          s.number = {state_i.number[15:8], rx_byte_i};
          s.phase  = (op == OpAck) ? PH_EXCESS : PH_PAY;
        end
      end
      PH_NAME: begin
        if (rx_byte_i == 8'h00) begin
          r.role     = ROLE_TERM;
          s.name_len = state_i.field_len;
          s.phase    = PH_MODE;
        end else begin
          r.role = ROLE_NAME;
        end
        if (state_i.field_len >= CntMax) s.bad = 1'b1;
        else s.field_len = state_i.field_len + 10'd1;
        if ({1'b0, s.field_len} > lim + 11'd1) s.bad = 1'b1;
      end
      PH_MODE: begin
        if (rx_byte_i == 8'h00) begin
          r.role = ROLE_TERM;
          // empty mode string
          if (state_i.match_idx == 3'd0 && !state_i.mismatch) s.bad = 1'b1;
          s.phase = PH_EXCESS;
        end else begin
          r.role = ROLE_MODE;
          if (state_i.match_idx < 3'd5 && lc == octet_char(state_i.match_idx)) begin
            s.match_idx = state_i.match_idx + 3'd1;
          end else begin
            s.mismatch = 1'b1;
          end
        end
        if (state_i.field_len >= CntMax) s.bad = 1'b1;
        else s.field_len = state_i.field_len + 10'd1;
        if ({1'b0, s.field_len} > lim + 11'd1) s.bad = 1'b1;
      end
      PH_PAY: begin
        if (op == OpData) begin
          r.role = ROLE_PAYLOAD;
          if (state_i.field_len >= CntMax) s.bad = 1'b1;
          else s.field_len = state_i.field_len + 10'd1;
          if ({1'b0, s.field_len} > lim) s.bad = 1'b1;
        end else if (rx_byte_i == 8'h00) begin
          r.role = ROLE_TERM;
          if ({1'b0, state_i.field_len} + 11'd1 > lim) s.bad = 1'b1;
          s.phase = PH_EXCESS;
        end else begin
          r.role = ROLE_PAYLOAD;
          if (state_i.field_len >= CntMax) s.bad = 1'b1;
          else s.field_len = state_i.field_len + 10'd1;
          if ({1'b0, s.field_len} + 11'd1 > lim) s.bad = 1'b1;
        end
      end
      default: begin
        r.role = ROLE_EXCESS;
        if (op == OpRrq || op == OpWrq || op == OpError) s.bad = 1'b1;
      end
    endcase

    op_num   = (op >= OpData) && (op <= OpError);
    op_req   = (op == OpRrq) || (op == OpWrq);
    mask_idx = op[2:0] - 3'd1;
    op_legal = (op >= OpRrq) && (op <= OpError) && cfg_i.opcode_mask[mask_idx];
    ended_ok = (s.phase == PH_EXCESS);

    r.byte_out = rx_byte_i;
    r.done     = last_i;
    r.status   = ST_OK;

    if (last_i) begin
      if (s.byte_count < 10'd2 || (op_num && s.byte_count < 10'd4)) begin
        r.status = ST_SHORT;
      end else if (s.bad) begin
        r.status = ST_BAD_REQ;
      end else if ((op_req || op == OpError) && !ended_ok) begin
        r.status = ST_BAD_REQ;
      end else if (!op_legal) begin
        r.status = ST_ILLEGAL_OP;
      end else if (op_req && (s.mismatch || s.match_idx != 3'd5)) begin
        r.status = ST_WRONG_MODE;
      end
      r.opcode      = (r.status == ST_OK) ? op : 16'd0;
      r.number      = op_num ? s.number : 16'd0;
      r.name_len    = op_req ? s.name_len : 10'd0;
      r.payload_len = (op == OpData || op == OpError) ? s.field_len : 10'd0;
      // start clean for the next datagram
      s = StateReset;
    end

    state_o = s;
    res_o   = r;
  end

endmodule

// ----- design/tpp_checker.sv -----
// Port-level assertions for the TFTP packet parser, bound to the top level.
`timescale 1ns / 1ps
module tpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import tpp_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // Every accepted byte yields a result beat in the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("no result after accepted byte");

  // Verdict fields stay zero on non-final beats
  a_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[63:8] == 56'd0)
    else $error("verdict fields set on non-final beat");

  // Rejected packets report opcode zero
  a_rej_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && m_axis_tdata_o[10:8] != ST_OK
      |-> m_axis_tdata_o[26:11] == 16'd0)
    else $error("rejected packet shows an opcode");

  // Role code is within range
  a_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= 3'(ROLE_EXCESS))
    else $error("role code out of range");

endmodule

bind tftp_packet_parser_core tpp_checker u_tpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
